### sv/nsc_pkg.sv
// ---------------------------------------------------------------------------
// NMEA sentence checker package
// Shared types, character codes, verdict codes and the hex digit decoder.
// ---------------------------------------------------------------------------
package nsc_pkg;

    // Default longest line kept, in bytes
    localparam int LINE_MAX_DEF = 128;

    // Largest number of header characters compared
    localparam int HDR_MAX = 8;

    // Widths fixed by the field list
    localparam int BYTE_W    = 8;
    localparam int VERDICT_W = 3;
    localparam int PATTERN_W = 64;
    localparam int HLEN_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = PATTERN_W;

    // Bits per hex digit (radix 16)
    localparam int HEX_DIGIT_W = 4;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_PATTERN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH  = 1'b1;

    // Verdict codes, first failing check wins
    typedef enum logic [VERDICT_W-1:0] {
        VD_ACCEPTED   = 3'd0,
        VD_NO_DOLLAR  = 3'd1,
        VD_NO_STAR    = 3'd2,
        VD_SUM_SHORT  = 3'd3,
        VD_MISMATCH   = 3'd4,
        VD_HDR_FAIL   = 3'd5
    } t_verdict;

    // Header configuration as seen by the line tracker
    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [HLEN_W-1:0]    length;   // already limited to HDR_MAX
    } t_cfg;

    // One verdict word
    typedef struct packed {
        t_verdict          verdict;
        logic [BYTE_W-1:0] computed_sum;
        logic [BYTE_W-1:0] received_sum;
        logic [BYTE_W-1:0] line_length;
        logic [BYTE_W-1:0] field_count;
    } t_result;

    // Decoded hex character
    typedef struct packed {
        logic                   bad;
        logic [HEX_DIGIT_W-1:0] value;
    } t_hex;

    // Decode one ASCII hex digit, either case
    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] c);
        t_hex h;
        h.bad   = 1'b0;
        h.value = '0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = HEX_DIGIT_W'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            h.value = HEX_DIGIT_W'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            h.value = HEX_DIGIT_W'(c - 8'h37);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

### sv/nsc_byte_if.sv
// ---------------------------------------------------------------------------
// NMEA sentence checker byte channel
// Valid/ready channel that carries one received byte per word.
// ---------------------------------------------------------------------------
interface nsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/nsc_result_if.sv
// ---------------------------------------------------------------------------
// NMEA sentence checker result channel
// Valid/ready channel that carries one line verdict per word.
// ---------------------------------------------------------------------------
interface nsc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [7:0] line_length;
    logic [7:0] field_count;

    modport source (output valid, output verdict, output computed_sum,
                    output received_sum, output line_length, output field_count,
                    input ready);
    modport sink   (input valid, input verdict, input computed_sum,
                    input received_sum, input line_length, input field_count,
                    output ready);
endinterface

### sv/nsc_line_tracker.sv
// ---------------------------------------------------------------------------
// NMEA sentence checker line tracker
// Input register plus the per-line running state: XOR, counters, star and
// hex tracking, header match. Forms the verdict word on carriage return.
// ---------------------------------------------------------------------------
module nsc_line_tracker #(
    parameter int LINE_MAX = nsc_pkg::LINE_MAX_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_byte,
    input  nsc_pkg::t_cfg           i_cfg,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output nsc_pkg::t_result        o_res
);
    import nsc_pkg::*;

    localparam int CNT_W = $clog2(LINE_MAX + 1);

    // Input register
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Line state
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic              r_star, n_star;
    logic [1:0]        r_cas, n_cas;
    logic [BYTE_W-1:0] r_hex, n_hex;
    logic              r_hex_bad, n_hex_bad;
    logic [BYTE_W-1:0] r_commas, n_commas;
    logic              r_dollar, n_dollar;
    logic              r_hdr_ok, n_hdr_ok;
    logic              r_zero, n_zero;

    logic              is_cr;
    logic              is_lf;
    logic              advance;
    logic              in_hdr;
    logic              hdr_final;
    logic [BYTE_W-1:0] want;
    t_hex              hd;
    t_verdict          verdict;

    assign is_cr   = (r_in_byte == CH_CR);
    assign is_lf   = (r_in_byte == CH_LF);
    // A carriage return waits for room in the result stage
    assign advance = r_in_valid && (!is_cr || i_res_ready);
    assign o_ready = !r_in_valid || advance;
    assign n_in_valid = o_ready ? i_valid : r_in_valid;

    assign in_hdr = (r_cnt < CNT_W'(i_cfg.length));
    assign want   = i_cfg.pattern[{r_cnt[2:0], 3'b000} +: BYTE_W];
    assign hd     = hex_decode(r_in_byte);

    // Update the line state for the byte in the input register
    always_comb begin
        n_cnt     = r_cnt;
        n_xor     = r_xor;
        n_star    = r_star;
        n_cas     = r_cas;
        n_hex     = r_hex;
        n_hex_bad = r_hex_bad;
        n_commas  = r_commas;
        n_dollar  = r_dollar;
        n_hdr_ok  = r_hdr_ok;
        n_zero    = r_zero;
        if (advance) begin
            if (is_cr) begin
                n_cnt     = '0;
                n_xor     = '0;
                n_star    = 1'b0;
                n_cas     = '0;
                n_hex     = '0;
                n_hex_bad = 1'b0;
                n_commas  = '0;
                n_dollar  = 1'b0;
                n_hdr_ok  = 1'b1;
                n_zero    = 1'b0;
            end else if (!is_lf && r_cnt < CNT_W'(LINE_MAX)) begin
                n_cnt = r_cnt + 1'b1;
                if (!r_zero) begin
                    if (r_in_byte == CH_NUL) begin
                        n_zero = 1'b1;
                        if (in_hdr) n_hdr_ok = 1'b0;
                    end else begin
                        if (in_hdr && r_in_byte != want) n_hdr_ok = 1'b0;
                        if (r_in_byte == CH_COMMA) n_commas = r_commas + 1'b1;
                        if (r_cnt == '0) begin
                            n_dollar = (r_in_byte == CH_DOLLAR);
                        end else if (!r_star) begin
                            if (r_in_byte == CH_STAR) n_star = 1'b1;
                            else n_xor = r_xor ^ r_in_byte;
                        end else if (r_cas != 2'd2) begin
                            if (hd.bad) n_hex_bad = 1'b1;
                            else n_hex = {r_hex[BYTE_W-HEX_DIGIT_W-1:0], hd.value};
                            n_cas = r_cas + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Form the verdict from the state held at the carriage return
    assign hdr_final = r_hdr_ok && !(!r_zero && in_hdr);

    always_comb begin
        if (!r_dollar) verdict = VD_NO_DOLLAR;
        else if (!r_star) verdict = VD_NO_STAR;
        else if (r_cas != 2'd2) verdict = VD_SUM_SHORT;
        else if (r_hex_bad || r_hex != r_xor) verdict = VD_MISMATCH;
        else if (!hdr_final) verdict = VD_HDR_FAIL;
        else verdict = VD_ACCEPTED;
    end

    assign o_res_valid        = r_in_valid && is_cr;
    assign o_res.verdict      = verdict;
    assign o_res.computed_sum = r_xor;
    assign o_res.received_sum = (r_cas == 2'd2 && !r_hex_bad) ? r_hex : '0;
    assign o_res.line_length  = BYTE_W'(r_cnt);
    assign o_res.field_count  = r_commas + 1'b1;

    // Hold the input byte and line state
    always_ff @(posedge i_clk) begin
        if (o_ready) r_in_byte <= i_byte;
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
            r_xor      <= '0;
            r_star     <= 1'b0;
            r_cas      <= '0;
            r_hex      <= '0;
            r_hex_bad  <= 1'b0;
            r_commas   <= '0;
            r_dollar   <= 1'b0;
            r_hdr_ok   <= 1'b1;
            r_zero     <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
            r_xor      <= n_xor;
            r_star     <= n_star;
            r_cas      <= n_cas;
            r_hex      <= n_hex;
            r_hex_bad  <= n_hex_bad;
            r_commas   <= n_commas;
            r_dollar   <= n_dollar;
            r_hdr_ok   <= n_hdr_ok;
            r_zero     <= n_zero;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(LINE_MAX))
        else $error("line counter past line limit");

    a_cr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_cr) |=> (r_cnt == '0 && r_hdr_ok && !r_star))
        else $error("line state not cleared after carriage return");

    a_hex_after_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cas != 2'd0 || r_hex_bad) |-> r_star)
        else $error("checksum digits tracked before star");
`endif

endmodule

### sv/nsc_result_stage.sv
// ---------------------------------------------------------------------------
// NMEA sentence checker result stage
// Output register that holds one verdict word until the receiver takes it.
// ---------------------------------------------------------------------------
module nsc_result_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    output logic             o_free,
    input  nsc_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_ready,
    output nsc_pkg::t_result o_res
);
    import nsc_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;
    logic    take;

    assign o_free  = !r_valid || i_ready;
    assign take    = i_load && o_free;
    assign n_valid = take ? 1'b1 : (i_ready ? 1'b0 : r_valid);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Load a new word, drop the old one once taken
    always_ff @(posedge i_clk) begin
        if (take) r_res <= i_res;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("result register not empty after reset");

    a_load_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_valid && r_res == $past(i_res)))
        else $error("loaded word not held");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_valid && !i_ready) |-> !take)
        else $error("pending word overwritten");
`endif

endmodule

### sv/nmea_sentence_checker_unit.sv
// ---------------------------------------------------------------------------
// NMEA sentence checker unit
// Checks NMEA 0183 sentences from a byte stream and issues one verdict word
// per line: dollar, star, checksum, header prefix, field count.
// ---------------------------------------------------------------------------
// Usage:
//   i_rx carries received bytes, one word per byte. Line feeds are skipped,
//   a carriage return closes the line and yields one word on o_res; all
//   other bytes produce nothing. Bytes beyond LINE_MAX in a line are dropped.
//   The header registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_data while the block is idle; index 0 is the header pattern,
//   index 1 the header length (values above eight count as eight).
//   Throughput: one byte per cycle while no carriage return waits for the
//   result register; the running XOR and counters are updated between the
//   input register and the result register. A carriage return's verdict
//   passes through the input register, then the result register, before
//   the receiver can take it.
//   Reset clears the line state, the header registers and both registers'
//   valid flags. When the receiver stalls, the verdict is held in the
//   result register; ordinary bytes keep flowing, and a further carriage
//   return waits in the input register, holding off the bytes behind it,
//   until the pending verdict has been taken.
// ---------------------------------------------------------------------------
module nmea_sentence_checker_unit #(
    parameter int LINE_MAX = nsc_pkg::LINE_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    nsc_byte_if.sink                       i_rx,
    nsc_result_if.source                   o_res,
    input  logic                           i_cfg_we,
    input  logic [nsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nsc_pkg::*;

    logic [PATTERN_W-1:0] r_pattern;
    logic [HLEN_W-1:0]    r_hlen;
    logic [HLEN_W-1:0]    n_hlen;
    t_cfg                 cfg;
    t_result              trk_res;
    t_result              out_res;
    logic                 trk_valid;
    logic                 stage_free;

    // Limit the header length to the pattern size
    assign n_hlen = (i_cfg_data[HLEN_W-1:0] > HLEN_W'(HDR_MAX)) ?
                    HLEN_W'(HDR_MAX) : i_cfg_data[HLEN_W-1:0];

    // Hold the header registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_hlen    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADER_PATTERN: r_pattern <= i_cfg_data;
                REG_HEADER_LENGTH:  r_hlen    <= n_hlen;
                default: ;
            endcase
        end
    end

    assign cfg.pattern = r_pattern;
    assign cfg.length  = r_hlen;

    nsc_line_tracker #(
        .LINE_MAX (LINE_MAX)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_rx.valid),
        .o_ready     (i_rx.ready),
        .i_byte      (i_rx.rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (trk_valid),
        .i_res_ready (stage_free),
        .o_res       (trk_res)
    );

    nsc_result_stage u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (trk_valid),
        .o_free  (stage_free),
        .i_res   (trk_res),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (out_res)
    );

    assign o_res.verdict      = out_res.verdict;
    assign o_res.computed_sum = out_res.computed_sum;
    assign o_res.received_sum = out_res.received_sum;
    assign o_res.line_length  = out_res.line_length;
    assign o_res.field_count  = out_res.field_count;

endmodule

### test/nmea_sentence_checker_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// NMEA sentence checker unit testbench
// Streams received bytes into the checker and compares every verdict word
// against a line tracker kept in the bench. Directed lines cover each verdict
// and corner case. Random sentences, mostly well formed, run under several
// header settings and idle patterns, with one long receiver hold-off.
// ---------------------------------------------------------------------------
module nmea_sentence_checker_unit_tb;
    import nsc_pkg::*;

    localparam int LAT_CYCLES      = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_ITEMS    = 500;
    localparam int HOLD_OFF_CYCLES = 300;

    // Kinds of damage applied to a random sentence
    typedef enum int {
        FLAW_NONE,
        FLAW_NO_DOLLAR,
        FLAW_NO_STAR,
        FLAW_SHORT,
        FLAW_BAD_HEX,
        FLAW_NUL,
        FLAW_TRAILER
    } t_flaw;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nsc_byte_if   rx_if ();
    nsc_result_if res_if ();

    nmea_sentence_checker_unit #(
        .LINE_MAX (LINE_MAX_DEF)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_if.sink),
        .o_res       (res_if.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Bench copy of the header registers
    logic [PATTERN_W-1:0] hdr_pattern;
    logic [HLEN_W-1:0]    hdr_len;

    // Bench copy of the line state
    logic [7:0] line_count;
    logic [7:0] line_xor;
    logic       star_found;
    logic [1:0] sum_digits;
    logic [7:0] sum_value;
    logic       sum_bad;
    logic [7:0] comma_total;
    logic       dollar_lead;
    logic       header_match;
    logic       nul_found;

    t_result    verdict_q[$];
    logic [7:0] line_buf[$];

    int errors        = 0;
    int sent_items    = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_cycles   = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Line tracker
    // -----------------------------------------------------------------------

    function automatic void clear_line();
        line_count   = '0;
        line_xor     = '0;
        star_found   = 1'b0;
        sum_digits   = '0;
        sum_value    = '0;
        sum_bad      = 1'b0;
        comma_total  = '0;
        dollar_lead  = 1'b0;
        header_match = 1'b1;
        nul_found    = 1'b0;
    endfunction

    // Decode one hex character into {bad, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b0, 4'(c - 8'h61 + 8'd10)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b0, 4'(c - 8'h41 + 8'd10)};
        end
        return 5'b10000;
    endfunction

    // Advance the line state by one accepted byte; queue a verdict on CR
    function automatic void track_byte(input logic [7:0] b);
        int unsigned hl;
        int unsigned pos;
        logic [4:0]  nib;
        t_result     r;
        hl = (hdr_len > HDR_MAX) ? HDR_MAX : hdr_len;
        if (b == CH_LF) begin
            return;
        end
        if (b != CH_CR) begin
            if (line_count < LINE_MAX_DEF && !nul_found) begin
                pos = line_count;
                if (b == CH_NUL) begin
                    nul_found = 1'b1;
                    if (pos < hl) header_match = 1'b0;
                end else begin
                    if (pos < hl && b != hdr_pattern[8*pos +: 8]) header_match = 1'b0;
                    if (b == CH_COMMA) comma_total = comma_total + 8'd1;
                    if (pos == 0) begin
                        dollar_lead = (b == CH_DOLLAR);
                    end else if (!star_found) begin
                        if (b == CH_STAR) star_found = 1'b1;
                        else line_xor = line_xor ^ b;
                    end else if (sum_digits < 2) begin
                        nib = hex_nibble(b);
                        if (nib[4]) sum_bad = 1'b1;
                        else sum_value = {sum_value[3:0], nib[3:0]};
                        sum_digits = sum_digits + 2'd1;
                    end
                end
            end
            if (line_count < LINE_MAX_DEF) line_count = line_count + 8'd1;
            return;
        end

        // Close the line
        if (!nul_found && line_count < hl) header_match = 1'b0;
        if (!dollar_lead) r.verdict = VD_NO_DOLLAR;
        else if (!star_found) r.verdict = VD_NO_STAR;
        else if (sum_digits < 2) r.verdict = VD_SUM_SHORT;
        else if (sum_bad || sum_value != line_xor) r.verdict = VD_MISMATCH;
        else if (!header_match) r.verdict = VD_HDR_FAIL;
        else r.verdict = VD_ACCEPTED;
        r.computed_sum = line_xor;
        r.received_sum = (sum_digits == 2 && !sum_bad) ? sum_value : 8'h00;
        r.line_length  = line_count;
        r.field_count  = comma_total + 8'd1;
        verdict_q.push_back(r);
        clear_line();
    endfunction

    // Driving helpers
    // -----------------------------------------------------------------------

    // Offer one byte word, idling first at random; returns at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        track_byte(b);
        sent_items++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    // Send a line of plain text closed by CR
    task automatic send_text(input string s);
        push_text(s);
        line_buf.push_back(CH_CR);
        send_line();
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10) return 8'h30 + n;
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    // Append a star and the correct checksum of the buffer so far
    task automatic push_sum();
        logic [7:0] sum;
        sum = '0;
        for (int i = 1; i < line_buf.size(); i++) sum = sum ^ line_buf[i];
        line_buf.push_back(CH_STAR);
        line_buf.push_back(hex_char(sum[7:4]));
        line_buf.push_back(hex_char(sum[3:0]));
    endtask

    function automatic logic [PATTERN_W-1:0] pattern_of(input string s);
        logic [PATTERN_W-1:0] p;
        p = '0;
        for (int i = 0; i < s.len() && i < HDR_MAX; i++) p[8*i +: 8] = s[i];
        return p;
    endfunction

    // Random header: dollar then seven printable characters, no star
    function automatic logic [PATTERN_W-1:0] random_pattern();
        logic [PATTERN_W-1:0] p;
        p[7:0] = CH_DOLLAR;
        for (int i = 1; i < HDR_MAX; i++) p[8*i +: 8] = 8'($urandom_range(8'h30, 8'h5A));
        return p;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        if (idx == REG_HEADER_PATTERN) hdr_pattern = data;
        else hdr_len = data[HLEN_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_header(input logic [PATTERN_W-1:0] pattern,
                              input logic [HLEN_W-1:0] len);
        write_reg(REG_HEADER_PATTERN, pattern);
        write_reg(REG_HEADER_LENGTH, CFG_DATA_W'(len));
    endtask

    // Drop valid, then wait until every verdict is in and the pipe is empty
    task automatic settle();
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES) @(posedge i_clk);
    endtask

    // Build and send one random sentence, well formed, damaged or noise
    task automatic send_random_sentence();
        int unsigned kind;
        int unsigned hl;
        int unsigned body_len;
        int unsigned digits;
        t_flaw       flaw;
        logic [7:0]  sum;
        logic [7:0]  c;
        kind = $urandom_range(0, 99);
        line_buf.delete();

        // Noise: any byte values, closed by CR
        if (kind >= 85) begin
            repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
            line_buf.push_back(CH_CR);
            send_line();
            return;
        end

        // Lead: the configured header most of the time, else a bare dollar
        hl = (hdr_len > HDR_MAX) ? HDR_MAX : hdr_len;
        if (hl > 0 && $urandom_range(0, 4) != 0) begin
            for (int i = 0; i < hl; i++) line_buf.push_back(hdr_pattern[8*i +: 8]);
        end else begin
            line_buf.push_back(CH_DOLLAR);
        end

        // Body: printable with many commas, a few high bytes, now and then long
        body_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 180)
                                                : $urandom_range(0, 20);
        repeat (body_len) begin
            if ($urandom_range(0, 4) == 0) c = CH_COMMA;
            else if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(8'h80, 8'hFF));
            else c = 8'($urandom_range(8'h20, 8'h7E));
            if (c == CH_STAR) c = CH_COMMA;
            line_buf.push_back(c);
        end

        sum = '0;
        for (int i = 1; i < line_buf.size(); i++) sum = sum ^ line_buf[i];
        if ($urandom_range(0, 6) == 0) sum = 8'($urandom_range(0, 255));

        flaw = (kind >= 70) ? t_flaw'($urandom_range(FLAW_NO_DOLLAR, FLAW_TRAILER))
                            : FLAW_NONE;
        if (flaw == FLAW_NO_DOLLAR) line_buf[0] = 8'($urandom_range(8'h41, 8'h5A));
        if (flaw == FLAW_NUL) line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);

        // Star and checksum digits
        if (flaw != FLAW_NO_STAR) begin
            line_buf.push_back(CH_STAR);
            digits = (flaw == FLAW_SHORT) ? $urandom_range(0, 1) : 2;
            if (digits > 0) line_buf.push_back(hex_char(sum[7:4]));
            if (digits > 1) line_buf.push_back(hex_char(sum[3:0]));
            if (flaw == FLAW_BAD_HEX) begin
                line_buf[line_buf.size() - $urandom_range(1, 2)] =
                    8'($urandom_range(8'h47, 8'h5A));
            end
            if (flaw == FLAW_TRAILER) begin
                repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
        end
        line_buf.push_back(CH_CR);
        if ($urandom_range(0, 1) != 0) line_buf.push_back(CH_LF);
        send_line();
    endtask

    // Tests
    // -----------------------------------------------------------------------

    // One line per verdict and corner case, header check off
    task automatic test_directed();
        // empty line
        send_text("");
        // accepted, characters past the two digits ignored, then a line feed
        send_text("$A*41Z");
        send_byte(CH_LF);
        // star in the first position is no star; lower-case non-hex digit
        send_text("*A*4g");
        // wrong sum
        send_text("$B*41");
        // non-hex digit after a dollar
        send_text("$A*4g");
        // one digit only, with a comma and a top-bit byte
        push_text("$,");
        line_buf.push_back(8'hFF);
        push_text("*F");
        line_buf.push_back(CH_CR);
        send_line();
        // zero byte hides the star behind it
        line_buf.push_back(CH_DOLLAR);
        line_buf.push_back(CH_NUL);
        line_buf.push_back(CH_STAR);
        line_buf.push_back(CH_CR);
        send_line();
        settle();
    endtask

    // Lines past the length limit: fullest field count and length
    task automatic test_line_limit();
        repeat (LINE_MAX_DEF + 12) line_buf.push_back(CH_COMMA);
        line_buf.push_back(CH_CR);
        send_line();
        line_buf.push_back(CH_DOLLAR);
        repeat (LINE_MAX_DEF + 20) line_buf.push_back(8'h41);
        push_sum();
        line_buf.push_back(CH_CR);
        send_line();
        settle();
    endtask

    // Header prefix: match, mismatch, checksum inside the header span, zero inside
    task automatic test_header_match();
        set_header(pattern_of("$GPGGA"), 4'd6);
        push_text("$GPGGA,1");
        push_sum();
        line_buf.push_back(CH_CR);
        send_line();
        push_text("$GPGGB,1");
        push_sum();
        line_buf.push_back(CH_CR);
        send_line();
        push_text("$GP");
        push_sum();
        line_buf.push_back(CH_CR);
        send_line();
        push_text("$GP");
        line_buf.push_back(CH_NUL);
        push_sum();
        line_buf.push_back(CH_CR);
        send_line();
        settle();
    endtask

    // Random sentences under one header setting and one idle pattern
    task automatic test_random_phase(input logic [PATTERN_W-1:0] pattern,
                                     input logic [HLEN_W-1:0] len,
                                     input int src_pct, input int snk_pct,
                                     input int n_items);
        int target;
        set_header(pattern, len);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        target = sent_items + n_items;
        while (sent_items < target) send_random_sentence();
        // the sender pauses here until every verdict has come back
        settle();
    endtask

    // Long receiver hold-off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 23;
        hold_cycles   = HOLD_OFF_CYCLES;
        repeat (10) send_random_sentence();
        settle();
    endtask

    // Result ready: long hold-off first, then random stalls
    initial begin : result_ready_driver
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // Compare one field of a verdict word
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Check every verdict word against the oldest prediction
    initial begin : verdict_checker
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict word, expected none, got verdict %0d",
                             $time, res_if.verdict);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("verdict", want.verdict, res_if.verdict);
                    check_field("computed_sum", want.computed_sum, res_if.computed_sum);
                    check_field("received_sum", want.received_sum, res_if.received_sum);
                    check_field("line_length", want.line_length, res_if.line_length);
                    check_field("field_count", want.field_count, res_if.field_count);
                end
            end
        end
    end

    // Watchdog
    initial begin : cycle_watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** nmea_sentence_checker_unit: FAILED **");
        $finish;
    end

    // Main sequence
    initial begin : main_sequence
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        hdr_pattern   = '0;
        hdr_len       = '0;
        clear_line();

        // hold reset, then release it at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_line_limit();
        test_header_match();
        test_random_phase('0, 4'd0, 0, 0, RANDOM_ITEMS / 5);
        test_random_phase({PATTERN_W{1'b1}}, 4'd15, 63, 0, RANDOM_ITEMS / 5);
        test_random_phase(random_pattern(), 4'd9, 0, 63, RANDOM_ITEMS / 5);
        test_random_phase(random_pattern(), 4'($urandom_range(1, HDR_MAX)), 23, 23,
                          RANDOM_ITEMS / 5);
        test_random_phase(pattern_of("$GPGGA"), 4'd6, 0, 0, RANDOM_ITEMS / 5);
        test_backpressure();

        settle();
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("** nmea_sentence_checker_unit: PASSED **");
        end else begin
            $display("** nmea_sentence_checker_unit: FAILED **");
        end
        $finish;
    end

endmodule
